// ===== sv/dccs_pkg.sv =====
// shared constants, types and sine table of the chord chime synthesizer
package dccs_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 8;
  localparam int LENGTH_BITS    = 16;

  localparam int NUM_TONES  = 4;
  localparam int TONE_IDX_W = $clog2(NUM_TONES);

  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int LENGTH_CFG_W = 16;
  localparam int ENV_W        = 25;
  localparam int GAIN_W       = 15;
  localparam int SAMPLE_W     = 16;
  localparam int SINE_W       = 15;
  localparam int ROM_SIZE     = 1 << SINE_ADDR_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_TONE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd6;

  localparam logic [CFG_DATA_W-1:0] TONE_STEP_RST [NUM_TONES] = '{
    32'd280917704, 32'd353932148, 32'd420901426, 32'd561835409
  };
  localparam logic [ENV_W-1:0]        DECAY_RST  = 25'd2097;
  localparam logic [GAIN_W-1:0]       GAIN_RST   = 15'd16384;
  localparam logic [LENGTH_CFG_W-1:0] LENGTH_RST = 16'd2500;
  localparam logic [ENV_W-1:0]        ENV_ONE    = 25'h1000000;

  // shared multiplier and mix datapath widths
  localparam int MUL_A_W   = ENV_W + 1;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W;
  localparam int MAG_W     = 42;
  localparam int LO_W      = ENV_W;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int MIX_SHIFT = 41;
  localparam int TOT_W     = MIX_SHIFT + SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] SAT_POS     = 16'd32767;
  localparam logic [SAMPLE_W-1:0] SAT_NEG_MAG = 16'd32768;

  typedef struct packed {
    logic                  rd_en;
    logic [TONE_IDX_W-1:0] addr;
    logic                  clear;
  } phase_ctl_t;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef logic [SINE_W-1:0] sine_rom_t [ROM_SIZE];

  // quarter-wave table from a Q30 odd polynomial, evaluated at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] v;
    for (int k = 0; k < ROM_SIZE; k++) begin
      x  = 64'(2 * k + 1) << (29 - SINE_ADDR_BITS);
      x2 = (x * x) >> 30;
      p  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
      p  = 64'd85569306 - ((x2 * p) >> 30);
      p  = 64'd693598668 - ((x2 * p) >> 30);
      p  = 64'd1686629713 - ((x2 * p) >> 30);
      s  = (x * p) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      rom[k] = (v > 64'd32767) ? 15'd32767 : v[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== sv/dccs_if.sv =====
// item channels of the chord chime synthesizer
interface dccs_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface dccs_out_if import dccs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] audio_sample;
  logic                       final_sample;
  logic                       active;
  modport source (output valid, output audio_sample, output final_sample, output active,
                  input ready);
  modport sink (input valid, input audio_sample, input final_sample, input active,
                output ready);
endinterface

// ===== sv/dccs_phase_mem.sv =====
// phase accumulator memory with read, advance and write-back
module dccs_phase_mem import dccs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  phase_ctl_t            ctl,
  input  logic [PHASE_BITS-1:0] steps [NUM_TONES],
  output logic [PHASE_BITS-1:0] phase,
  output logic                  phase_vld
);

  logic [PHASE_BITS-1:0] mem [NUM_TONES];
  logic [PHASE_BITS-1:0] rdata_r;
  logic [TONE_IDX_W-1:0] addr_r;
  logic                  clear_r;
  logic                  vld_r;

  assign phase     = clear_r ? '0 : rdata_r;
  assign phase_vld = vld_r;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[ctl.addr];
      addr_r  <= ctl.addr;
      clear_r <= ctl.clear;
    end
    if (vld_r) begin
      mem[addr_r] <= phase + steps[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.rd_en;
    end
  end

  // read never targets the entry being written back
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && ctl.rd_en) |-> (ctl.addr != addr_r))
    else $error("phase read collides with write-back");

  a_vld_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_en |=> vld_r)
    else $error("phase data valid missing after read");

  a_clear_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && ctl.rd_en) |-> (ctl.clear == clear_r))
    else $error("phase clear changed within one sample");

endmodule

// ===== sv/dccs_mul.sv =====
// shared signed multiplier with registered product
module dccs_mul import dccs_pkg::*; (
  input  logic                     clk,
  input  mul_req_t                 req,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= $signed(req.a) * $signed(req.b);
    end
  end

endmodule

// ===== sv/decaying_chord_chime_synth.sv =====
// top level of the four-voice decaying chord chime synthesizer
//
//   channel  dir  fields                                  handshake
//   in_ch    in   restart                                 valid/ready
//   out_ch   out  audio_sample, final_sample, active      valid/ready
//   cfg_*    in   cfg_index, cfg_data                     cfg_we, no wait
//
// a running sample passes from the accept cycle through the mix step, which
// streams the four voices through the phase memory and the shared multiplier,
// then abs, two gain partial products and finish. a silent tick goes from
// accept straight to finish. reset is synchronous; the phase memory needs
// no clearing since a chime only starts on restart, which zeroes the phases.
// a stalled output holds the finished sample in the finish step.
module decaying_chord_chime_synth import dccs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dccs_in_if.sink               in_ch,
  dccs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MIX_LAST = NUM_TONES + 2;
  localparam int CNT_W    = $clog2(MIX_LAST + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MIX  = 6'b000010,
    ST_ABS  = 6'b000100,
    ST_GLO  = 6'b001000,
    ST_GHI  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;

  logic [PHASE_BITS-1:0]      tone_step_r [NUM_TONES];
  logic [ENV_W-1:0]           decay_r;
  logic [GAIN_W-1:0]          gain_r;
  logic [LENGTH_BITS-1:0]     length_r;

  logic [ENV_W-1:0]           env_r;
  logic [LENGTH_BITS-1:0]     idx_r;
  logic                       running_r;
  logic                       restart_r;
  logic                       silent_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SAMPLE_W-1:0] sine_r;
  logic                       v2_r;
  logic                       v3_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       neg_r;
  logic [PROD_W-1:0]          lo_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_final_r;
  logic                       out_active_r;

  phase_ctl_t                 ph_ctl;
  logic [PHASE_BITS-1:0]      phase;
  logic                       phase_vld;
  mul_req_t                   mul_req;
  logic signed [PROD_W-1:0]   prod;

  logic                       in_acc;
  logic                       load;
  logic [1:0]                 quad;
  logic [SINE_ADDR_BITS-1:0]  rom_k;
  logic signed [SAMPLE_W-1:0] sine_mag;
  logic signed [SAMPLE_W-1:0] sine;
  logic [TOT_W-1:0]           total;
  logic [SAMPLE_W-1:0]        m;
  logic signed [SAMPLE_W-1:0] smp;
  logic                       last;

  dccs_phase_mem u_phase_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ph_ctl),
    .steps     (tone_step_r),
    .phase     (phase),
    .phase_vld (phase_vld)
  );

  dccs_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign load                = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.audio_sample = out_sample_r;
  assign out_ch.final_sample = out_final_r;
  assign out_ch.active       = out_active_r;

  assign ph_ctl.rd_en = (state_r == ST_MIX) && (cnt_r < CNT_W'(NUM_TONES));
  assign ph_ctl.addr  = cnt_r[TONE_IDX_W-1:0];
  assign ph_ctl.clear = restart_r;

  // quarter-wave lookup
  assign quad     = phase[PHASE_BITS-1 -: 2];
  assign rom_k    = quad[0] ? ~phase[PHASE_BITS-3 -: SINE_ADDR_BITS]
                            : phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
  assign sine_mag = {1'b0, SINE_ROM[rom_k]};
  assign sine     = quad[1] ? -sine_mag : sine_mag;

  always_comb begin
    mul_req = '0;
    unique case (state_r)
      ST_MIX: begin
        mul_req.en = v2_r;
        mul_req.a  = {1'b0, env_r};
        mul_req.b  = MUL_B_W'(sine_r);
      end
      ST_GLO: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, mag_r[LO_W-1:0]};
        mul_req.b  = MUL_B_W'(gain_r);
      end
      ST_GHI: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_A_W'(mag_r[MAG_W-1:LO_W]);
        mul_req.b  = MUL_B_W'(gain_r);
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // gain product from two partial products, then saturate
  assign total = (TOT_W'($unsigned(prod)) << LO_W) + TOT_W'(lo_r);
  assign m     = total[TOT_W-1 -: SAMPLE_W];
  assign last  = (idx_r == LENGTH_BITS'(length_r - 1'b1));

  always_comb begin
    if (neg_r) begin
      smp = (m > SAT_NEG_MAG) ? $signed(SAT_NEG_MAG) : $signed(SAMPLE_W'(-m));
    end else begin
      smp = (m > SAT_POS) ? $signed(SAT_POS) : $signed(m);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.restart || running_r) ? ST_MIX : ST_FIN;
        end
      end
      ST_MIX: begin
        if (cnt_r == CNT_W'(MIX_LAST)) begin
          state_nxt = ST_ABS;
        end
      end
      ST_ABS:  state_nxt = ST_GLO;
      ST_GLO:  state_nxt = ST_GHI;
      ST_GHI:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      restart_r <= in_ch.restart;
      silent_r  <= !(in_ch.restart || running_r);
      acc_r     <= '0;
    end
    if (phase_vld) begin
      sine_r <= sine;
    end
    if (v3_r) begin
      acc_r <= acc_r + prod;
    end
    if (state_r == ST_ABS) begin
      neg_r <= acc_r[ACC_W-1];
      mag_r <= MAG_W'(acc_r[ACC_W-1] ? -acc_r : acc_r);
    end
    if (state_r == ST_GHI) begin
      lo_r <= $unsigned(prod);
    end
    if (load) begin
      out_sample_r <= silent_r ? '0 : smp;
      out_final_r  <= !silent_r && last;
      out_active_r <= !silent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      running_r   <= 1'b0;
      env_r       <= ENV_ONE;
      idx_r       <= '0;
      for (int i = 0; i < NUM_TONES; i++) begin
        tone_step_r[i] <= PHASE_BITS'(TONE_STEP_RST[i]);
      end
      decay_r     <= DECAY_RST;
      gain_r      <= GAIN_RST;
      length_r    <= LENGTH_BITS'(LENGTH_RST);
    end else begin
      state_r <= state_nxt;
      v2_r    <= phase_vld;
      v3_r    <= v2_r;
      if (in_acc) begin
        cnt_r <= '0;
      end else if (state_r == ST_MIX) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (in_acc && in_ch.restart) begin
        running_r <= 1'b1;
        env_r     <= ENV_ONE;
        idx_r     <= '0;
      end
      if (load && !silent_r) begin
        env_r <= (env_r > decay_r) ? env_r - decay_r : '0;
        idx_r <= idx_r + 1'b1;
        if (last) begin
          running_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index) inside
          REG_TONE_A, REG_TONE_B, REG_TONE_C, REG_TONE_D: begin
            tone_step_r[cfg_index[TONE_IDX_W-1:0]] <= PHASE_BITS'(cfg_data);
          end
          REG_DECAY:  decay_r  <= cfg_data[ENV_W-1:0];
          REG_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
          REG_LENGTH: length_r <= LENGTH_BITS'(cfg_data[LENGTH_CFG_W-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

  a_acc_in_mix: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (state_r == ST_MIX))
    else $error("voice product accumulated outside the mix step");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(phase_vld || v2_r || v3_r))
    else $error("item accepted while voices still in flight");

  a_active_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !silent_r) |-> running_r)
    else $error("chime sample produced while not running");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !silent_r && last) |=> !running_r)
    else $error("chime kept running after its last sample");

endmodule
